@@ design/sbt_pkg.sv @@
package sbt_pkg;

  // Fixed field widths.
  localparam int COORD_BITS = 32;
  localparam int DIM_W      = 4;   // holds a dimension address up to 16 dimensions
  localparam int NDIM_W     = 5;   // holds a dimension count up to 16
  localparam int CODE_W     = 11;
  localparam int COUNT_W    = 8;
  localparam int TOTAL_W    = 16;
  localparam int OUT_DIM_W  = 3;

  // Constants of the split arithmetic.
  localparam logic [COORD_BITS-1:0] WIDTH_TWO   = 32'h8000_0000;
  localparam logic [COORD_BITS-1:0] THIRD_RECIP = 32'hAAAA_AAAB;  // ceil(2^33 / 3)
  localparam int                    THIRD_SHIFT = 33;
  localparam logic [9:0]            MIDDLE_BASE = 10'd100;
  localparam logic [15:0]           HUND_RECIP  = 16'd41;         // 41 / 2^12 ~ 1 / 100
  localparam int                    HUND_SHIFT  = 12;
  localparam logic [COUNT_W-1:0]    COUNT_MAX   = 8'hFF;
  localparam logic [TOTAL_W-1:0]    TOTAL_MAX   = 16'hFFFF;

  // Configuration register indexes (address bit 2).
  localparam logic [0:0] REG_SPLIT_RULE  = 1'b0;
  localparam logic [0:0] REG_ACTIVE_DIMS = 1'b1;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_SPLIT = 2'd1,
    MODE_POINT = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // One decoded item on its way from the input to the update stage.
  typedef struct packed {
    mode_t                   op;
    logic                    split_ok;
    logic                    left;
    logic                    middle;
    logic                    last;
    logic [DIM_W-1:0]        addr;
    logic [COORD_BITS-1:0]   point;
  } sbt_item_t;

  // One dimension of the box as held in the state memory.
  typedef struct packed {
    logic [COORD_BITS-1:0] center;
    logic [COORD_BITS-1:0] width;
    logic [COUNT_W-1:0]    count;
  } sbt_entry_t;

  // One result item.
  typedef struct packed {
    logic [OUT_DIM_W-1:0]  dim_index;
    logic [COORD_BITS-1:0] center;
    logic [COORD_BITS-1:0] width;
    logic [COUNT_W-1:0]    count;
    logic [TOTAL_W-1:0]    total;
    logic                  coord_inside;
    logic                  point_done;
    logic                  point_inside;
    logic                  status;
  } sbt_result_t;

endpackage

@@ design/sbt_decode.sv @@
module sbt_decode #(
  parameter int AW       = 3
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic [1:0]                           mode,
  input  logic signed [sbt_pkg::CODE_W-1:0]    split_code,
  input  logic signed [sbt_pkg::COORD_BITS-1:0] point_value,
  input  logic [sbt_pkg::NDIM_W-1:0]           ndims,
  output sbt_pkg::sbt_item_t                   item,
  output logic [AW-1:0]                        rd_addr
);

  logic [AW-1:0]                 qpos_r;
  logic [AW-1:0]                 qpos_nxt;
  logic [AW-1:0]                 pos;
  logic                          last;
  logic                          neg;
  logic [sbt_pkg::CODE_W-1:0]    mag;
  logic                          middle;
  logic [15:0]                   hund_prod;
  logic [sbt_pkg::CODE_W-1:0]    dim;
  logic                          split_ok;
  logic [sbt_pkg::CODE_W-1:0]    dim_m1;
  sbt_pkg::mode_t                op;

  assign op = sbt_pkg::mode_t'(mode);

  // Split code decode: sign picks left, hundreds pick a middle split.
  assign neg       = split_code[sbt_pkg::CODE_W-1];
  assign mag       = neg ? (~split_code + 1'b1) : split_code;
  assign middle    = !neg && (split_code[9:0] >= sbt_pkg::MIDDLE_BASE);
  assign hund_prod = 16'(split_code[9:0]) * sbt_pkg::HUND_RECIP;
  assign dim       = middle ? sbt_pkg::CODE_W'(hund_prod[15:sbt_pkg::HUND_SHIFT]) : mag;
  assign split_ok  = (dim != '0) && (dim <= sbt_pkg::CODE_W'(ndims));
  assign dim_m1    = dim - 1'b1;

  // Point coordinates walk the active dimensions in order.
  assign pos  = (sbt_pkg::NDIM_W'(qpos_r) >= ndims) ? '0 : qpos_r;
  assign last = (sbt_pkg::NDIM_W'(pos) + 1'b1) >= ndims;

  always_comb begin
    qpos_nxt = qpos_r;
    case (op)
      sbt_pkg::MODE_CLEAR: qpos_nxt = '0;
      sbt_pkg::MODE_POINT: qpos_nxt = last ? '0 : AW'(pos + 1'b1);
      default:             qpos_nxt = qpos_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qpos_r <= '0;
    end else if (accept) begin
      qpos_r <= qpos_nxt;
    end
  end

  // Assemble the item for the update stage.
  always_comb begin
    item          = '0;
    item.op       = op;
    item.split_ok = split_ok;
    item.left     = neg;
    item.middle   = middle;
    item.last     = last;
    item.point    = point_value;
    if (op == sbt_pkg::MODE_POINT) begin
      item.addr = sbt_pkg::DIM_W'(pos);
    end else begin
      item.addr = dim_m1[sbt_pkg::DIM_W-1:0];
    end
  end

  assign rd_addr = item.addr[AW-1:0];

endmodule

@@ design/sbt_mem.sv @@
module sbt_mem #(
  parameter int MAX_DIMS = 8,
  parameter int AW       = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output sbt_pkg::sbt_entry_t rd_entry,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  sbt_pkg::sbt_entry_t wr_entry,
  input  logic                clr
);

  sbt_pkg::sbt_entry_t mem [MAX_DIMS];
  sbt_pkg::sbt_entry_t rd_data_r;
  logic [AW-1:0]       rd_addr_r;
  logic [MAX_DIMS-1:0] valid_r;
  logic                fwd_valid_r;
  logic [AW-1:0]       fwd_addr_r;
  sbt_pkg::sbt_entry_t fwd_data_r;
  sbt_pkg::sbt_entry_t reset_entry;

  // Storage array, synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // Per-entry valid bits stand in for clearing the array; the last write
  // is kept so a read racing that write still sees the new data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      fwd_valid_r <= 1'b0;
    end else if (clr) begin
      valid_r     <= '0;
      fwd_valid_r <= 1'b0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
      fwd_valid_r      <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr_r <= wr_addr;
      fwd_data_r <= wr_entry;
    end
  end

  always_comb begin
    reset_entry        = '0;
    reset_entry.width  = sbt_pkg::WIDTH_TWO;
  end

  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == rd_addr_r)) begin
      rd_entry = fwd_data_r;
    end else if (valid_r[rd_addr_r]) begin
      rd_entry = rd_data_r;
    end else begin
      rd_entry = reset_entry;
    end
  end

endmodule

@@ design/sbt_update.sv @@
module sbt_update (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  sbt_pkg::sbt_item_t  item,
  input  sbt_pkg::sbt_entry_t entry,
  input  logic                split_rule,
  output logic                wr_req,
  output logic                clr_req,
  output sbt_pkg::sbt_entry_t wr_entry,
  output sbt_pkg::sbt_result_t result
);

  localparam int CB = sbt_pkg::COORD_BITS;

  logic [sbt_pkg::TOTAL_W-1:0] total_r;
  logic [sbt_pkg::TOTAL_W-1:0] total_nxt;
  logic                        qall_r;
  logic                        qall_nxt;

  logic [CB-1:0]        w;
  logic [2*CB-1:0]      prod;
  logic [CB-1:0]        third;
  logic [CB-1:0]        new_w;
  logic [CB-1:0]        step;
  logic signed [CB:0]   c_ext;
  logic signed [CB:0]   step_s;
  logic signed [CB:0]   c_sum;
  logic [CB-1:0]        new_c;
  logic [sbt_pkg::COUNT_W-1:0] new_cnt;
  logic [sbt_pkg::TOTAL_W-1:0] inc_total;
  logic signed [CB:0]   diff;
  logic [CB:0]          abs_diff;
  logic                 coord_in;

  assign w = entry.width;

  // Width divided by three through the reciprocal multiply.
  assign prod  = {{CB{1'b0}}, w} * {{CB{1'b0}}, sbt_pkg::THIRD_RECIP};
  assign third = CB'(prod[2*CB-1:sbt_pkg::THIRD_SHIFT]);

  always_comb begin
    if (split_rule) begin
      new_w = third;
      step  = item.middle ? '0 : third;
    end else begin
      new_w = w >> 1;
      step  = w >> 2;
    end
  end

  // Move the center and saturate to the signed coordinate range.
  assign c_ext  = {entry.center[CB-1], entry.center};
  assign step_s = item.left ? -$signed({1'b0, step}) : $signed({1'b0, step});
  assign c_sum  = c_ext + step_s;

  always_comb begin
    if (c_sum[CB] != c_sum[CB-1]) begin
      new_c = c_sum[CB] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
    end else begin
      new_c = c_sum[CB-1:0];
    end
  end

  assign new_cnt   = (entry.count == sbt_pkg::COUNT_MAX) ? entry.count
                                                         : entry.count + 1'b1;
  assign inc_total = (total_r == sbt_pkg::TOTAL_MAX) ? total_r : total_r + 1'b1;

  // Point test: |p - c| <= w / 2, done as 2 * |p - c| <= w.
  assign diff     = $signed({item.point[CB-1], item.point}) - c_ext;
  assign abs_diff = diff[CB] ? '0 - diff : diff;
  assign coord_in = {abs_diff, 1'b0} <= {2'b00, w};

  assign wr_entry.center = new_c;
  assign wr_entry.width  = new_w;
  assign wr_entry.count  = new_cnt;
  assign wr_req  = (item.op == sbt_pkg::MODE_SPLIT) && item.split_ok;
  assign clr_req = (item.op == sbt_pkg::MODE_CLEAR);

  // Result fields and next scalar state.
  always_comb begin
    result    = '0;
    total_nxt = total_r;
    qall_nxt  = qall_r;
    case (item.op)
      sbt_pkg::MODE_CLEAR: begin
        result.width = sbt_pkg::WIDTH_TWO;
        total_nxt    = '0;
        qall_nxt     = 1'b1;
      end
      sbt_pkg::MODE_SPLIT: begin
        if (item.split_ok) begin
          result.dim_index = sbt_pkg::OUT_DIM_W'(item.addr);
          result.center    = new_c;
          result.width     = new_w;
          result.count     = new_cnt;
          result.total     = inc_total;
          total_nxt        = inc_total;
        end else begin
          result.total  = total_r;
          result.status = 1'b1;
        end
      end
      sbt_pkg::MODE_POINT: begin
        result.dim_index    = sbt_pkg::OUT_DIM_W'(item.addr);
        result.center       = entry.center;
        result.width        = entry.width;
        result.count        = entry.count;
        result.total        = total_r;
        result.coord_inside = coord_in;
        if (item.last) begin
          result.point_done   = 1'b1;
          result.point_inside = qall_r & coord_in;
          qall_nxt            = 1'b1;
        end else begin
          qall_nxt = qall_r & coord_in;
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      qall_r  <= 1'b1;
    end else if (adv) begin
      total_r <= total_nxt;
      qall_r  <= qall_nxt;
    end
  end

endmodule

@@ design/split_box_tracker_core.sv @@
// Split box tracker core.
// Keeps an axis-aligned box in Q2.30 over up to MAX_DIMS dimensions. Each
// input item either clears the box, applies one split code, or tests one
// point coordinate against the next active dimension in turn.
// Input channel: in_valid / in_stall with in_mode, in_split_code and
// in_point_value; an item is taken at an edge with in_valid high and
// in_stall low. Output channel: out_valid / out_stall, one result item per
// input item, in order.
// A taken item waits in the update stage register; its result then waits
// in the output register while out_stall is high. Throughput: one item per
// cycle, but a stalled result can raise in_stall. Per-dimension state sits
// in a small synchronous memory; each item reads its dimension when taken
// and writes it back on leaving the update stage, with the latest write
// forwarded so back-to-back items on the same dimension see fresh data.
// Configuration goes through the APB-style port: split_rule at byte address
// 0 and active_dims at byte address 4; pready is always high.
// Reset brings the box to center 0, width 2.0, all counters to zero, rules
// to halving and eight active dimensions; no clearing pass is needed.
// While out_stall is high and a result waits, one more item can be held in
// the update stage; after that in_stall rises in the same cycle.
module split_box_tracker_core #(
  parameter int MAX_DIMS = 8
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic signed [10:0] in_split_code,
  input  logic signed [31:0] in_point_value,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_dim_index,
  output logic signed [31:0] out_center_value,
  output logic [31:0] out_width_value,
  output logic [7:0]  out_dim_split_count,
  output logic [15:0] out_total_splits,
  output logic        out_coord_inside,
  output logic        out_point_done,
  output logic        out_point_inside,
  output logic        out_status,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  logic                          split_rule_r;
  logic [3:0]                    active_dims_r;
  logic [sbt_pkg::NDIM_W-1:0]    ndims;
  logic                          cfg_wr;

  sbt_pkg::sbt_item_t            dec_item;
  logic [AW-1:0]                 rd_addr;
  sbt_pkg::sbt_item_t            b_item_r;
  logic                          b_valid_r;
  sbt_pkg::sbt_entry_t           rd_entry;
  sbt_pkg::sbt_entry_t           wr_entry;
  logic                          wr_req;
  logic                          clr_req;
  sbt_pkg::sbt_result_t          result;
  sbt_pkg::sbt_result_t          out_r;
  logic                          out_valid_r;

  logic                          accept;
  logic                          out_free;
  logic                          b_adv;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_rule_r  <= 1'b0;
      active_dims_r <= 4'd8;
    end else if (cfg_wr) begin
      unique case (paddr[2:2])
        sbt_pkg::REG_SPLIT_RULE:  split_rule_r  <= pwdata[0];
        sbt_pkg::REG_ACTIVE_DIMS: active_dims_r <= pwdata[3:0];
        default:                  split_rule_r  <= split_rule_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2:2])
      sbt_pkg::REG_SPLIT_RULE:  prdata = {31'd0, split_rule_r};
      sbt_pkg::REG_ACTIVE_DIMS: prdata = {28'd0, active_dims_r};
      default:                  prdata = '0;
    endcase
  end

  // Effective dimension count, clamped to 1..MAX_DIMS.
  always_comb begin
    if (active_dims_r == '0) begin
      ndims = sbt_pkg::NDIM_W'(1);
    end else if (sbt_pkg::NDIM_W'(active_dims_r) > sbt_pkg::NDIM_W'(MAX_DIMS)) begin
      ndims = sbt_pkg::NDIM_W'(MAX_DIMS);
    end else begin
      ndims = sbt_pkg::NDIM_W'(active_dims_r);
    end
  end

  // Pipeline flow: input stage, update stage, output register.
  assign out_free = !out_valid_r || !out_stall;
  assign b_adv    = b_valid_r && out_free;
  assign in_stall = b_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  sbt_decode #(
    .AW       (AW)
  ) u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .mode        (in_mode),
    .split_code  (in_split_code),
    .point_value (in_point_value),
    .ndims       (ndims),
    .item        (dec_item),
    .rd_addr     (rd_addr)
  );

  sbt_mem #(
    .MAX_DIMS (MAX_DIMS),
    .AW       (AW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr_en    (b_adv && wr_req),
    .wr_addr  (b_item_r.addr[AW-1:0]),
    .wr_entry (wr_entry),
    .clr      (b_adv && clr_req)
  );

  // Update stage item register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (accept) begin
      b_valid_r <= 1'b1;
    end else if (b_adv) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_item_r <= dec_item;
    end
  end

  sbt_update u_update (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (b_adv),
    .item       (b_item_r),
    .entry      (rd_entry),
    .split_rule (split_rule_r),
    .wr_req     (wr_req),
    .clr_req    (clr_req),
    .wr_entry   (wr_entry),
    .result     (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_r <= result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_dim_index       = out_r.dim_index;
  assign out_center_value    = out_r.center;
  assign out_width_value     = out_r.width;
  assign out_dim_split_count = out_r.count;
  assign out_total_splits    = out_r.total;
  assign out_coord_inside    = out_r.coord_inside;
  assign out_point_done      = out_r.point_done;
  assign out_point_inside    = out_r.point_inside;
  assign out_status          = out_r.status;

endmodule

@@ design/sbt_checker.sv @@
module sbt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_center_value,
  input logic [31:0] out_width_value,
  input logic [15:0] out_total_splits,
  input logic        out_coord_inside,
  input logic        out_point_done,
  input logic        out_point_inside
);

  // No result is shown in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_center_value) &&
      $stable(out_width_value) && $stable(out_total_splits))
    else $error("stalled result changed");

  // The input side only stalls behind a stalled, waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // A point reported inside must end the point on an inside coordinate.
  a_point_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_inside |-> out_point_done && out_coord_inside)
    else $error("point inside without a completed inside coordinate");

endmodule

bind split_box_tracker_core sbt_checker u_sbt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_center_value (out_center_value),
  .out_width_value  (out_width_value),
  .out_total_splits (out_total_splits),
  .out_coord_inside (out_coord_inside),
  .out_point_done   (out_point_done),
  .out_point_inside (out_point_inside)
);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;

  // One input item as the sender offers it.
  typedef struct {
    sbt_pkg::mode_t     mode;
    logic signed [10:0] code;
    logic signed [31:0] point;
  } box_cmd_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_mode = 2'd0;
  logic signed [10:0]  in_split_code = '0;
  logic signed [31:0]  in_point_value = '0;

  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [2:0]          out_dim_index;
  logic signed [31:0]  out_center_value;
  logic [31:0]         out_width_value;
  logic [7:0]          out_dim_split_count;
  logic [15:0]         out_total_splits;
  logic                out_coord_inside;
  logic                out_point_done;
  logic                out_point_inside;
  logic                out_status;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  split_box_tracker_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_split_code       (in_split_code),
    .in_point_value      (in_point_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_dim_index       (out_dim_index),
    .out_center_value    (out_center_value),
    .out_width_value     (out_width_value),
    .out_dim_split_count (out_dim_split_count),
    .out_total_splits    (out_total_splits),
    .out_coord_inside    (out_coord_inside),
    .out_point_done      (out_point_done),
    .out_point_inside    (out_point_inside),
    .out_status          (out_status),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Shadow of the box state and the configuration registers.
  logic                rule_thirds = 1'b0;
  logic [3:0]          dims_reg = 4'd8;
  logic signed [31:0]  box_ctr [8];
  logic [31:0]         box_wid [8];
  logic [7:0]          dim_cnt [8];
  logic [15:0]         split_sum;
  logic [2:0]          query_pos;
  logic                query_all_in;

  box_cmd_t             pending_cmds [$];
  sbt_pkg::sbt_result_t expected_results [$];
  box_cmd_t             live_cmd;

  bit in_taken = 1'b0;
  bit idle_on = 1'b1;
  bit hold_arm = 1'b0;
  bit hold_done = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int cycles = 0;
  int fail_count = 0;
  int result_count = 0;
  int n_clear = 0, n_split = 0, n_reject = 0, n_thin = 0, n_coord = 0;
  int n_point = 0, n_point_in = 0, n_held = 0;

  function automatic int dims_in_use(input logic [3:0] r);
    if (r == 4'd0) return 1;
    if (r > 4'd8) return 8;
    return int'(r);
  endfunction

  function automatic void reset_box();
    for (int i = 0; i < 8; i++) begin
      box_ctr[i] = '0;
      box_wid[i] = sbt_pkg::WIDTH_TWO;
      dim_cnt[i] = '0;
    end
    split_sum    = '0;
    query_pos    = '0;
    query_all_in = 1'b1;
  endfunction

  // Advance the shadow box by one item and return the result it should give.
  function automatic sbt_pkg::sbt_result_t track_box(input box_cmd_t c);
    sbt_pkg::sbt_result_t r;
    int          nd, code, dimn, d;
    bit          left, mid;
    longint      w, t, step, cn, p, offset;
    logic        coord_in;
    r    = '0;
    nd   = dims_in_use(dims_reg);
    left = 1'b0;
    mid  = 1'b0;
    d    = 0;
    case (c.mode)
      sbt_pkg::MODE_CLEAR: begin
        reset_box();
        r.width = sbt_pkg::WIDTH_TWO;
      end
      sbt_pkg::MODE_SPLIT: begin
        code = c.code;
        if (code < 0) begin
          dimn = -code;
          left = 1'b1;
        end else if (code < 100) begin
          dimn = code;
        end else begin
          dimn = code / 100;
          mid  = 1'b1;
        end
        if (dimn < 1 || dimn > nd) begin
          r.total  = split_sum;
          r.status = 1'b1;
        end else begin
          d = dimn - 1;
          w = {32'd0, box_wid[d]};
          if (rule_thirds) begin
            t = w / 3;
            step = mid ? 0 : (left ? -t : t);
            box_wid[d] = t[31:0];
          end else begin
            step = left ? -(w >>> 2) : (w >>> 2);
            box_wid[d] = w[32:1];
          end
          cn = longint'(box_ctr[d]) + step;
          if (cn > 64'sd2147483647) cn = 64'sd2147483647;
          if (cn < -64'sd2147483648) cn = -64'sd2147483648;
          box_ctr[d] = cn[31:0];
          if (dim_cnt[d] != sbt_pkg::COUNT_MAX) dim_cnt[d]++;
          if (split_sum != sbt_pkg::TOTAL_MAX) split_sum++;
          r.dim_index = d[2:0];
          r.center    = box_ctr[d];
          r.width     = box_wid[d];
          r.count     = dim_cnt[d];
          r.total     = split_sum;
        end
      end
      sbt_pkg::MODE_POINT: begin
        d = (int'(query_pos) >= nd) ? 0 : int'(query_pos);
        p = longint'(c.point) - longint'(box_ctr[d]);
        offset = (p < 0) ? -p : p;
        coord_in = (2 * offset <= longint'({32'd0, box_wid[d]}));
        r.dim_index    = d[2:0];
        r.center       = box_ctr[d];
        r.width        = box_wid[d];
        r.count        = dim_cnt[d];
        r.total        = split_sum;
        r.coord_inside = coord_in;
        if (d + 1 >= nd) begin
          r.point_done   = 1'b1;
          r.point_inside = query_all_in & coord_in;
          query_pos      = '0;
          query_all_in   = 1'b1;
        end else begin
          query_pos    = 3'(d + 1);
          query_all_in = query_all_in & coord_in;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Random item: mostly well-formed splits and coordinates near box edges.
  function automatic box_cmd_t gen_cmd(input int nd, input int clear_pct);
    box_cmd_t c;
    int       roll, d, k, j;
    longint   lv;
    c.mode  = sbt_pkg::MODE_SPLIT;
    c.code  = 11'($urandom);
    c.point = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < clear_pct) begin
      c.mode = sbt_pkg::MODE_CLEAR;
    end else if (roll < clear_pct + 3) begin
      c.mode = sbt_pkg::MODE_NONE;
    end else if (roll < 55) begin
      // A fifth of the split codes stay as random noise.
      if ($urandom_range(0, 9) < 8) begin
        d = $urandom_range(1, nd);
        case ($urandom_range(0, 2))
          0: c.code = 11'(-d);
          1: c.code = 11'(d);
          default: c.code = 11'(d * 100 + $urandom_range(0, 99));
        endcase
      end
    end else begin
      c.mode = sbt_pkg::MODE_POINT;
      case ($urandom_range(0, 5))
        0: ;
        1, 2: begin
          k = $urandom_range(0, 32);
          j = $urandom_range(0, 4);
          c.point = (k - 16) * (1 << 26) + j - 2;
        end
        3, 4: begin
          lv = $urandom_range(0, 32'h8000_0000);
          lv = lv - 64'sd1073741824;
          c.point = lv[31:0];
        end
        default: begin
          case ($urandom_range(0, 2))
            0: c.point = 32'sh7FFF_FFFF;
            1: c.point = 32'sh8000_0000;
            default: c.point = '0;
          endcase
        end
      endcase
    end
    return c;
  endfunction

  task automatic add_cmd(input sbt_pkg::mode_t m, input int code, input logic [31:0] pt);
    box_cmd_t c;
    c.mode  = m;
    c.code  = 11'(code);
    c.point = pt;
    pending_cmds.push_back(c);
  endtask

  // Register write through the configuration port: setup, then access.
  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == sbt_pkg::REG_SPLIT_RULE) rule_thirds = val[0];
    else dims_reg = val[3:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait until every offered item has been taken and answered.
  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(input logic rule, input logic [3:0] dims, input int count,
                            input int clear_pct, input bit arm_hold);
    write_reg(sbt_pkg::REG_SPLIT_RULE, {31'd0, rule});
    write_reg(sbt_pkg::REG_ACTIVE_DIMS, {28'd0, dims});
    if (arm_hold) hold_arm = 1'b1;
    repeat (count) pending_cmds.push_back(gen_cmd(dims_in_use(dims), clear_pct));
    drain();
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender: offers the next pending item, with random gaps.
  always @(negedge clk) begin
    box_cmd_t c;
    if (rst_n && (!in_valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 15);
        in_valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        c = pending_cmds.pop_front();
        live_cmd       <= c;
        in_mode        <= c.mode;
        in_split_code  <= c.code;
        in_point_value <= c.point;
        in_valid       <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts and one long hold-off.
  always @(negedge clk) begin
    if (hold_arm && !hold_done) begin
      hold_done  <= 1'b1;
      stall_left <= LONG_HOLD;
      out_stall  <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Predict on every taken item and check every delivered result.
  always @(posedge clk) begin
    sbt_pkg::sbt_result_t want, got;
    in_taken = rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && in_stall) n_held++;
    if (in_taken) begin
      want = track_box(live_cmd);
      expected_results.push_back(want);
      case (live_cmd.mode)
        sbt_pkg::MODE_CLEAR: n_clear++;
        sbt_pkg::MODE_SPLIT: begin
          n_split++;
          if (want.status) n_reject++;
          else if (want.width == '0) n_thin++;
        end
        sbt_pkg::MODE_POINT: begin
          n_coord++;
          if (want.point_done) n_point++;
          if (want.point_inside) n_point_in++;
        end
        default: ;
      endcase
    end
    if (rst_n && out_valid && !out_stall) begin
      got.dim_index    = out_dim_index;
      got.center       = out_center_value;
      got.width        = out_width_value;
      got.count        = out_dim_split_count;
      got.total        = out_total_splits;
      got.coord_inside = out_coord_inside;
      got.point_done   = out_point_done;
      got.point_inside = out_point_inside;
      got.status       = out_status;
      result_count++;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result %0d arrived with none expected", result_count);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("result %0d mismatch (dim center width count total ci pd pi st)",
                     result_count);
            $display("  expected %0d %h %h %0d %0d %b %b %b %b", want.dim_index,
                     want.center, want.width, want.count, want.total, want.coord_inside,
                     want.point_done, want.point_inside, want.status);
            $display("  actual   %0d %h %h %0d %0d %b %b %b %b", got.dim_index,
                     got.center, got.width, got.count, got.total, got.coord_inside,
                     got.point_done, got.point_inside, got.status);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    reset_box();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Halving rule, all eight dimensions: every split kind, rejected codes,
    // the unused mode and coordinate extremes.
    write_reg(sbt_pkg::REG_SPLIT_RULE, 32'd0);
    write_reg(sbt_pkg::REG_ACTIVE_DIMS, 32'd8);
    add_cmd(sbt_pkg::MODE_CLEAR, 0, 32'h0);
    add_cmd(sbt_pkg::MODE_SPLIT, -1, 32'h0);
    add_cmd(sbt_pkg::MODE_SPLIT, 1, 32'h0);
    add_cmd(sbt_pkg::MODE_SPLIT, 100, 32'h0);
    add_cmd(sbt_pkg::MODE_SPLIT, -8, 32'h0);
    add_cmd(sbt_pkg::MODE_SPLIT, 8, 32'h0);
    add_cmd(sbt_pkg::MODE_SPLIT, 899, 32'h0);
    add_cmd(sbt_pkg::MODE_SPLIT, 0, 32'h0);
    add_cmd(sbt_pkg::MODE_SPLIT, 9, 32'h0);
    add_cmd(sbt_pkg::MODE_SPLIT, -9, 32'h0);
    add_cmd(sbt_pkg::MODE_SPLIT, 900, 32'h0);
    add_cmd(sbt_pkg::MODE_SPLIT, 1023, 32'h0);
    add_cmd(sbt_pkg::MODE_SPLIT, -1024, 32'h0);
    add_cmd(sbt_pkg::MODE_NONE, 1023, 32'hFFFF_FFFF);
    add_cmd(sbt_pkg::MODE_POINT, 0, 32'h7FFF_FFFF);
    add_cmd(sbt_pkg::MODE_POINT, 0, 32'h8000_0000);
    add_cmd(sbt_pkg::MODE_POINT, 0, 32'h0);
    add_cmd(sbt_pkg::MODE_POINT, 0, 32'h4000_0000);
    add_cmd(sbt_pkg::MODE_POINT, 0, 32'hC000_0000);
    add_cmd(sbt_pkg::MODE_POINT, 0, 32'h2000_0000);
    add_cmd(sbt_pkg::MODE_POINT, 0, 32'h0);
    add_cmd(sbt_pkg::MODE_POINT, 0, 32'h1000_0000);
    // A point left half done for the change of dimension count below.
    add_cmd(sbt_pkg::MODE_POINT, 0, 32'h0);
    add_cmd(sbt_pkg::MODE_POINT, 0, 32'h0);
    add_cmd(sbt_pkg::MODE_POINT, 0, 32'h0);
    drain();

    // Thirds rule with two dimensions: the pending coordinate wraps to
    // dimension zero, then left, right and middle thirds and a rejected code.
    write_reg(sbt_pkg::REG_SPLIT_RULE, 32'd1);
    write_reg(sbt_pkg::REG_ACTIVE_DIMS, 32'd2);
    add_cmd(sbt_pkg::MODE_POINT, 0, 32'h0);
    add_cmd(sbt_pkg::MODE_POINT, 0, 32'h0);
    add_cmd(sbt_pkg::MODE_SPLIT, -1, 32'h0);
    add_cmd(sbt_pkg::MODE_SPLIT, 2, 32'h0);
    add_cmd(sbt_pkg::MODE_SPLIT, 150, 32'h0);
    add_cmd(sbt_pkg::MODE_SPLIT, -3, 32'h0);
    drain();

    run_random(1'b0, 4'd8, 300, 3, 1'b0);
    run_random(1'b1, 4'd3, 300, 3, 1'b1);
    // No clears here, so widths shrink to zero.
    run_random(1'b1, 4'd0, 500, 0, 1'b0);
    run_random(1'b0, 4'd15, 300, 2, 1'b0);
    idle_on = 1'b0;
    run_random(1'b1, 4'd1, 300, 3, 1'b0);

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) fail_count += expected_results.size();

    $display("covered %0d results: %0d clears, %0d splits (%0d rejected, %0d at zero width)",
             result_count, n_clear, n_split, n_reject, n_thin);
    $display("%0d coordinates, %0d full points (%0d inside), input held back %0d cycles",
             n_coord, n_point, n_point_in, n_held);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
